// ===== rtl/cnf_pkg.sv =====
// Package for the console number and character formatter.
// Holds the mode codes, digit base codes, ASCII constants and the digit-to-ASCII function.
// Depends on nothing.
package cnf_pkg;

   localparam logic [2:0] FUNC_CHAR = 3'd0;
   localparam logic [2:0] FUNC_SDEC = 3'd1;
   localparam logic [2:0] FUNC_UDEC = 3'd2;
   localparam logic [2:0] FUNC_HEX  = 3'd3;
   localparam logic [2:0] FUNC_BIN  = 3'd4;

   typedef logic [1:0] base_type;
   localparam base_type BASE_DEC = 2'd0;
   localparam base_type BASE_HEX = 2'd1;
   localparam base_type BASE_BIN = 2'd2;

   // floor(v / 10) == (v * RECIP10) >> 35 for every 32-bit v.
   localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = CHAR_UPPER_A + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

// ===== rtl/cnf_digit_unit.sv =====
// Shared digit step: splits the working value into quotient and low digit for base 10, 16 or 2.
// Base 10 uses a registered reciprocal product; depends on cnf_pkg.
module cnf_digit_unit
   import cnf_pkg::*;
(
   input  logic        clock,
   input  logic        mul_en,
   input  logic [31:0] work,
   input  base_type    base,
   output logic [31:0] quot,
   output logic [3:0]  digit
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [3:0]  q10_low;

   assign prod_in = work * RECIP10;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // The remainder is below ten, so four bits of work - 10*q are exact.
   assign q10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};

   always_comb begin
      unique case (base)
         BASE_DEC: begin
            quot  = {3'b000, prod_ff[63:RECIP_SHIFT]};
            digit = work[3:0] - q10_low;
         end
         BASE_HEX: begin
            quot  = {4'b0000, work[31:4]};
            digit = work[3:0];
         end
         BASE_BIN: begin
            quot  = {1'b0, work[31:1]};
            digit = {3'b000, work[0]};
         end
         default: begin
            quot  = 32'd0;
            digit = 4'd0;
         end
      endcase
   end

endmodule

// ===== rtl/console_number_and_char_formatter.sv =====
// Top level of the console number and character formatter: sequencer, digit buffer, output register.
// Depends on cnf_pkg and cnf_digit_unit.
//
//   channel   ports                                  transfer when
//   request   start, busy, req_func, req_value       start high and busy low
//   response  rsp_strobe, rsp_char_out, rsp_last     rsp_strobe high (one strobe per byte)
//
// A number goes through states S_MUL and S_DIV for each digit in the shared digit unit,
// S_SIGN for a minus sign and S_READ for each digit read from the buffer; bytes appear in
// the cycle after each read. An escaped character goes out as a backslash and three octal
// digits. Busy is low again in the cycle that shows the final byte. Unused mode codes are
// dropped with no response. Reset is synchronous and clears the sequencer and the response strobe.
// The receiver cannot stall: every byte is on the ports for exactly one cycle.
module console_number_and_char_formatter
   import cnf_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SIGN = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_ESC  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [31:0]      work_ff, work_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   base_type         base_ff, base_in;
   logic             minus_ff, minus_in;
   logic [7:0]       esc_ff, esc_in;
   logic [1:0]       esc_idx_ff, esc_idx_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_last_ff, out_last_in;
   logic             out_mem_ff, out_mem_in;
   logic [7:0]       direct_ff, direct_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       digit_buf [MAX_DIGITS];

   logic             accept;
   logic [31:0]      quot;
   logic [3:0]       digit;
   logic [CNT_W-1:0] count_next;
   logic             buf_we;
   logic             buf_re;
   logic [7:0]       req_byte;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign req_byte   = req_value[7:0];
   assign count_next = count_ff + CNT_W'(1);

   cnf_digit_unit u_digit (
      .clock  (clock),
      .mul_en (state_ff == S_MUL),
      .work   (work_ff),
      .base   (base_ff),
      .quot   (quot),
      .digit  (digit)
   );

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      base_in      = base_ff;
      minus_in     = minus_ff;
      esc_in       = esc_ff;
      esc_idx_in   = esc_idx_ff;
      out_valid_in = 1'b0;
      out_last_in  = 1'b0;
      out_mem_in   = 1'b0;
      direct_in    = direct_ff;
      buf_we       = 1'b0;
      buf_re       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_func == FUNC_CHAR) begin
                  out_valid_in = 1'b1;
                  if ((req_byte >= CHAR_SPACE && req_byte < CHAR_DEL) ||
                      req_byte == CHAR_LF || req_byte == CHAR_TAB) begin
                     direct_in   = req_byte;
                     out_last_in = 1'b1;
                  end else begin
                     direct_in  = CHAR_BSLASH;
                     esc_in     = req_byte;
                     esc_idx_in = 2'd1;
                     state_in   = S_ESC;
                  end
               end else if (req_func == FUNC_SDEC || req_func == FUNC_UDEC ||
                            req_func == FUNC_HEX || req_func == FUNC_BIN) begin
                  count_in = '0;
                  minus_in = (req_func == FUNC_SDEC) && req_value[31];
                  work_in  = ((req_func == FUNC_SDEC) && req_value[31]) ?
                             (32'd0 - req_value) : req_value;
                  if (req_func == FUNC_HEX) begin
                     base_in = BASE_HEX;
                  end else if (req_func == FUNC_BIN) begin
                     base_in = BASE_BIN;
                  end else begin
                     base_in = BASE_DEC;
                  end
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            buf_we    = 1'b1;
            count_in  = count_next;
            work_in   = quot;
            rd_idx_in = count_ff[IDX_W-1:0];
            if (count_next == CNT_W'(MAX_DIGITS) || quot == 32'd0) begin
               if (minus_ff && count_next < CNT_W'(MAX_DIGITS)) begin
                  state_in = S_SIGN;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               state_in = S_MUL;
            end
         end
         S_SIGN: begin
            out_valid_in = 1'b1;
            direct_in    = CHAR_MINUS;
            state_in     = S_READ;
         end
         S_READ: begin
            buf_re       = 1'b1;
            out_valid_in = 1'b1;
            out_mem_in   = 1'b1;
            out_last_in  = (rd_idx_ff == '0);
            if (rd_idx_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
            end
         end
         S_ESC: begin
            out_valid_in = 1'b1;
            esc_idx_in   = esc_idx_ff + 2'd1;
            unique case (esc_idx_ff)
               2'd1:    direct_in = CHAR_ZERO + {6'b0, esc_ff[7:6]};
               2'd2:    direct_in = CHAR_ZERO + {5'b0, esc_ff[5:3]};
               default: direct_in = CHAR_ZERO + {5'b0, esc_ff[2:0]};
            endcase
            if (esc_idx_ff == 2'd3) begin
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         work_ff      <= 32'd0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         work_ff      <= work_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      base_ff     <= base_in;
      minus_ff    <= minus_in;
      esc_ff      <= esc_in;
      esc_idx_ff  <= esc_idx_in;
      out_last_ff <= out_last_in;
      out_mem_ff  <= out_mem_in;
      direct_ff   <= direct_in;
   end

   // Digit buffer, least significant digit first.
   always_ff @(posedge clock) begin
      if (buf_we) begin
         digit_buf[count_ff[IDX_W-1:0]] <= digit_char(digit);
      end
      if (buf_re) begin
         rd_data_ff <= digit_buf[rd_idx_ff];
      end
   end

   assign rsp_strobe   = out_valid_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_char_out = out_mem_ff ? rd_data_ff : direct_ff;

   a_div_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ($past(state_ff) == S_MUL))
      else $error("digit step entered without a product");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count exceeds buffer depth");

   a_esc_streams: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ESC) |-> out_valid_ff)
      else $error("gap inside an escape sequence");

   a_read_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (out_valid_ff && out_mem_ff))
      else $error("buffer read without a response transfer");

   a_unused_func: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func > FUNC_BIN) |=> (!out_valid_ff && state_ff == S_IDLE))
      else $error("unused mode produced activity");

endmodule

// ===== verif/console_number_and_char_formatter_test.sv =====
// Self-checking testbench for console_number_and_char_formatter: directed table, then random items.
// Expected text comes from typed table strings or a local formatter model; depends on cnf_pkg and the RTL top level.
module console_number_and_char_formatter_test;
   import cnf_pkg::*;

   localparam int DIGIT_LIMIT = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;
   localparam int DIRECTED_COUNT = 26;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int MAX_PRINTED = 100;

   // Mode codes that the block drops without a response.
   localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } console_byte_type;

   typedef struct {
      logic [2:0]  func;
      logic [31:0] value;
      bit          typed;
      string       text;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_func = FUNC_CHAR;
   logic [31:0] req_value = 32'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   console_byte_type expected_text[$];
   int               error_count = 0;
   int               stall_cycles = 0;
   stim_row_type     directed_rows [DIRECTED_COUNT];
   int               idle_pct [4] = '{0, 52, 0, 14};

   console_number_and_char_formatter #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_char_out(rsp_char_out),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("%0t: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic void expect_byte(input logic [7:0] ch, input logic last);
      expected_text.push_back('{ch, last});
   endfunction

   // Formats one request into the bytes the console should print.
   function automatic void format_request(input logic [2:0] func, input logic [31:0] value);
      logic [7:0]  ch;
      logic [31:0] magnitude;
      logic [31:0] digit;
      logic [31:0] base;
      logic [7:0]  digits [DIGIT_LIMIT];
      logic        negative;
      int          count;
      if (func == FUNC_CHAR) begin
         ch = value[7:0];
         if ((ch >= CHAR_SPACE && ch < CHAR_DEL) || ch == CHAR_LF || ch == CHAR_TAB) begin
            expect_byte(ch, 1'b1);
         end else begin
            expect_byte(CHAR_BSLASH, 1'b0);
            expect_byte(CHAR_ZERO + {6'b0, ch[7:6]}, 1'b0);
            expect_byte(CHAR_ZERO + {5'b0, ch[5:3]}, 1'b0);
            expect_byte(CHAR_ZERO + {5'b0, ch[2:0]}, 1'b1);
         end
      end else if (func <= FUNC_BIN) begin
         negative = (func == FUNC_SDEC) && value[31];
         magnitude = negative ? 32'd0 - value : value;
         base = (func == FUNC_HEX) ? 32'd16 : (func == FUNC_BIN) ? 32'd2 : 32'd10;
         count = 0;
         do begin
            digit = magnitude % base;
            digits[count] = (digit < 32'd10) ? CHAR_ZERO + digit[7:0]
                                             : CHAR_UPPER_A + digit[7:0] - 8'd10;
            count++;
            magnitude = magnitude / base;
         end while (count < DIGIT_LIMIT && magnitude != 32'd0);
         if (negative && count < DIGIT_LIMIT) begin
            expect_byte(CHAR_MINUS, 1'b0);
         end
         for (int i = count - 1; i >= 0; i--) begin
            expect_byte(digits[i], i == 0);
         end
      end
   endfunction

   // Presents one request and returns in the time step of its transfer.
   task automatic send_request(input logic [2:0] func, input logic [31:0] value,
                               input bit typed, input string text, input int pct);
      int gap;
      gap = ($urandom_range(99) < pct) ? $urandom_range(48, 1) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (typed) begin
         for (int i = 0; i < text.len(); i++) begin
            expect_byte(text[i], i == text.len() - 1);
         end
      end else begin
         format_request(func, value);
      end
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] value;
      case ($urandom_range(5))
         0: value = $urandom;
         1: value = $urandom_range(255);
         2: value = $urandom_range(99999);
         3: begin
            value = 32'd1 << $urandom_range(31);
            if ($urandom_range(1) == 1) begin
               value = value - 32'd1;
            end
         end
         4: value = 32'h8000_0000 | $urandom;
         default: value = ~32'($urandom_range(1000));
      endcase
      return value;
   endfunction

   // Response checker and watchdog; outputs are sampled at the edge that ends the cycle.
   always @(posedge clock) begin
      console_byte_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected byte 0x%02h last %b",
                                         rsp_char_out, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_out !== want.ch) begin
                  report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                            rsp_char_out, want.ch));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %b, expected %b on byte 0x%02h",
                                            rsp_last, want.last, want.ch));
               end
            end
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("console_number_and_char_formatter_test: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [2:0]  func;
      logic [31:0] value;
      int          done;
      directed_rows = '{
         '{FUNC_CHAR, 32'h0000_0041, 1'b1, "A"},
         '{FUNC_CHAR, 32'h0000_0020, 1'b1, " "},
         '{FUNC_CHAR, 32'h0000_007E, 1'b1, "~"},
         '{FUNC_CHAR, 32'h0000_000A, 1'b1, "\n"},
         '{FUNC_CHAR, 32'h0000_0009, 1'b1, "\t"},
         '{FUNC_CHAR, 32'h0000_0000, 1'b1, "\\000"},
         '{FUNC_CHAR, 32'h0000_007F, 1'b1, "\\177"},
         '{FUNC_CHAR, 32'h0000_00FF, 1'b1, "\\377"},
         '{FUNC_CHAR, 32'h0000_001F, 1'b0, ""},
         '{FUNC_CHAR, 32'hFFFF_FF80, 1'b1, "\\200"},
         '{FUNC_SDEC, 32'h0000_0000, 1'b1, "0"},
         '{FUNC_SDEC, 32'h7FFF_FFFF, 1'b1, "2147483647"},
         '{FUNC_SDEC, 32'h8000_0000, 1'b1, "-2147483648"},
         '{FUNC_SDEC, 32'hFFFF_FFFF, 1'b1, "-1"},
         '{FUNC_UDEC, 32'h0000_0000, 1'b1, "0"},
         '{FUNC_UDEC, 32'hFFFF_FFFF, 1'b1, "4294967295"},
         '{FUNC_UDEC, 32'h0000_000A, 1'b0, ""},
         '{FUNC_HEX,  32'h0000_0000, 1'b1, "0"},
         '{FUNC_HEX,  32'hFFFF_FFFF, 1'b1, "FFFFFFFF"},
         '{FUNC_HEX,  32'h0000_ABCD, 1'b0, ""},
         '{FUNC_BIN,  32'h0000_0000, 1'b1, "0"},
         '{FUNC_BIN,  32'hFFFF_FFFF, 1'b0, ""},
         '{FUNC_BIN,  32'h8000_0000, 1'b0, ""},
         '{FUNC_SPARE_5, 32'hFFFF_FFFF, 1'b1, ""},
         '{FUNC_SPARE_6, 32'h1234_5678, 1'b1, ""},
         '{FUNC_SPARE_7, 32'h0000_0000, 1'b1, ""}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].func, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].text, 0);
      end
      // Random phases with different amounts of sender idling; dropped codes are noise.
      foreach (idle_pct[p]) begin
         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 6) begin
               func = 3'($urandom_range(FUNC_SPARE_7, FUNC_SPARE_5));
            end else begin
               func = 3'($urandom_range(FUNC_BIN, FUNC_CHAR));
               done++;
            end
            value = pick_value();
            send_request(func, value, 1'b0, "", idle_pct[p]);
         end
      end
      start <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("console_number_and_char_formatter_test: PASS");
      end else begin
         $display("console_number_and_char_formatter_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== console_number_and_char_formatter.f =====
rtl/cnf_pkg.sv
rtl/cnf_digit_unit.sv
rtl/console_number_and_char_formatter.sv
verif/console_number_and_char_formatter_test.sv
